FILE: rtl/lcdw_pkg.sv
package lcdw_pkg;

  // controller memory size
  localparam logic [15:0] CTRL_COLUMNS = 16'd240;
  localparam logic [15:0] CTRL_ROWS    = 16'd320;

  localparam int COORD_W = 9;
  localparam int CTRL_W  = 16;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_X_OFFSET     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_OFFSET     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 3'd4;

  // rotation codes
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  // request codes
  localparam logic REQ_WINDOW = 1'b0;
  localparam logic REQ_MADCTL = 1'b1;

  // controller commands
  localparam logic [7:0] CMD_CASET  = 8'h2A;
  localparam logic [7:0] CMD_RASET  = 8'h2B;
  localparam logic [7:0] CMD_RAMWR  = 8'h2C;
  localparam logic [7:0] CMD_MADCTL = 8'h36;

  // request queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic               req_type;
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] last_x;
    logic [COORD_W-1:0] last_y;
  } in_item_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_command;
    logic       end_of_transfer;
  } out_item_t;

  // classified request as held in the queue
  typedef struct packed {
    logic              is_madctl;
    logic [7:0]        madctl;
    logic [CTRL_W-1:0] x0;
    logic [CTRL_W-1:0] x1;
    logic [CTRL_W-1:0] y0;
    logic [CTRL_W-1:0] y1;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  function automatic logic [7:0] madctl_byte(input logic [1:0] rot);
    logic [7:0] val;
    case (rot)
      ROT_0:   val = 8'b0000_0000;
      ROT_90:  val = 8'b1010_0000;
      ROT_180: val = 8'b1100_0000;
      ROT_270: val = 8'b0110_0000;
      default: val = 8'b0000_0000;
    endcase
    return val;
  endfunction

endpackage

FILE: rtl/lcd_window_command_generator.sv
// SPI LCD command generator. A request is taken on a clock edge with start high and
// busy low; a window request yields eleven bytes (0x2A, four column bytes, 0x2B,
// four row bytes, 0x2C) and an orientation request yields two (0x36, MADCTL byte),
// each byte on out_item for one cycle with out_strobe high and end_of_transfer set on
// the last byte of the request. The receiver cannot stall: bytes leave at one per
// cycle while requests are queued, from the single byte sequencer. An accepted
// request is written into the queue, and each of its bytes is registered in the
// output stage once the byte sequencer reaches that request. Up to four
// requests wait in a queue; busy is high while it is full. Configuration writes
// (cfg_ready is always high) take effect at once and must only be made while no
// request is outstanding.
module lcd_window_command_generator (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            start,
  output logic                            busy,
  input  lcdw_pkg::in_item_t              in_item,
  // byte stream
  output logic                            out_strobe,
  output lcdw_pkg::out_item_t             out_item,
  // register writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lcdw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcdw_pkg::COORD_W-1:0]    cfg_data
);
  import lcdw_pkg::*;

  logic      push;
  logic      pop;
  job_t      front_job;
  job_t      head_job;
  q_status_t q_status;

  // register writes never wait
  assign cfg_ready = 1'b1;
  // stall the requester only when the queue has no free slot
  assign busy = q_status.full;

  // front: register file, corner mapping and request classification
  lcdw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .job       (front_job)
  );

  // short queue so the front keeps taking requests while bytes go out
  lcdw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .job_in  (front_job),
    .pop     (pop),
    .job_out (head_job),
    .status  (q_status)
  );

  // back: byte sequencer with a registered output stage
  lcdw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job        (head_job),
    .status     (q_status),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

FILE: rtl/lcdw_front.sv
module lcdw_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  lcdw_pkg::in_item_t              in_item,
  input  logic                            cfg_valid,
  input  logic [lcdw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lcdw_pkg::COORD_W-1:0]    cfg_data,
  output logic                            push,
  output lcdw_pkg::job_t                  job
);
  import lcdw_pkg::*;

  logic [COORD_W-1:0] x_offset_r;
  logic [COORD_W-1:0] y_offset_r;
  logic [COORD_W-1:0] panel_width_r;
  logic [COORD_W-1:0] panel_height_r;
  logic [1:0]         rotation_r;

  logic [CTRL_W-1:0] row_base;
  logic [CTRL_W-1:0] col_base;
  logic [CTRL_W-1:0] xbase;
  logic [CTRL_W-1:0] ybase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_offset_r     <= '0;
      y_offset_r     <= '0;
      panel_width_r  <= COORD_W'(240);
      panel_height_r <= COORD_W'(320);
      rotation_r     <= ROT_0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_X_OFFSET:     x_offset_r     <= cfg_data;
        CFG_Y_OFFSET:     y_offset_r     <= cfg_data;
        CFG_PANEL_WIDTH:  panel_width_r  <= cfg_data;
        CFG_PANEL_HEIGHT: panel_height_r <= cfg_data;
        CFG_ROTATION:     rotation_r     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // panel origin in controller memory, wrapping at 16 bits
  assign row_base = CTRL_ROWS - CTRL_W'(y_offset_r) - CTRL_W'(panel_height_r);
  assign col_base = CTRL_COLUMNS - CTRL_W'(x_offset_r) - CTRL_W'(panel_width_r);

  always_comb begin
    case (rotation_r)
      ROT_0: begin
        xbase = CTRL_W'(x_offset_r);
        ybase = CTRL_W'(y_offset_r);
      end
      ROT_90: begin
        xbase = row_base;
        ybase = CTRL_W'(x_offset_r);
      end
      ROT_180: begin
        xbase = col_base;
        ybase = row_base;
      end
      default: begin
        xbase = CTRL_W'(y_offset_r);
        ybase = col_base;
      end
    endcase
  end

  assign push = start && !busy;

  always_comb begin
    job.is_madctl = (in_item.req_type == REQ_MADCTL);
    job.madctl    = madctl_byte(rotation_r);
    job.x0        = xbase + CTRL_W'(in_item.first_x);
    job.x1        = xbase + CTRL_W'(in_item.last_x);
    job.y0        = ybase + CTRL_W'(in_item.first_y);
    job.y1        = ybase + CTRL_W'(in_item.last_y);
  end

endmodule

FILE: rtl/lcdw_queue.sv
module lcdw_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lcdw_pkg::job_t       job_in,
  input  logic                 pop,
  output lcdw_pkg::job_t       job_out,
  output lcdw_pkg::q_status_t  status
);
  import lcdw_pkg::*;

  job_t              q_mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) n = '0;
    else n = p + QPTR_W'(1);
    return n;
  endfunction

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign job_out      = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= job_in;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && status.full))
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && status.empty))
    else $error("pop from empty queue");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + QCNT_W'(1)))
    else $error("queue count missed a push");

endmodule

FILE: rtl/lcdw_back.sv
module lcdw_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcdw_pkg::job_t       job,
  input  lcdw_pkg::q_status_t  status,
  output logic                 pop,
  output logic                 out_strobe,
  output lcdw_pkg::out_item_t  out_item
);
  import lcdw_pkg::*;

  localparam logic [3:0] B_CASET  = 4'd0;
  localparam logic [3:0] B_X0_HI  = 4'd1;
  localparam logic [3:0] B_X0_LO  = 4'd2;
  localparam logic [3:0] B_X1_HI  = 4'd3;
  localparam logic [3:0] B_X1_LO  = 4'd4;
  localparam logic [3:0] B_RASET  = 4'd5;
  localparam logic [3:0] B_Y0_HI  = 4'd6;
  localparam logic [3:0] B_Y0_LO  = 4'd7;
  localparam logic [3:0] B_Y1_HI  = 4'd8;
  localparam logic [3:0] B_Y1_LO  = 4'd9;
  localparam logic [3:0] B_RAMWR  = 4'd10;
  localparam logic [3:0] B_MADCTL = 4'd1;

  logic [3:0] byte_idx_r, byte_idx_nxt;
  logic       out_strobe_r, out_strobe_nxt;
  out_item_t  out_item_r, out_item_nxt;
  logic       active;
  logic       last_byte;

  assign active    = !status.empty;
  assign last_byte = job.is_madctl ? (byte_idx_r == B_MADCTL) : (byte_idx_r == B_RAMWR);
  assign pop       = active && last_byte;

  always_comb begin
    out_item_nxt.is_command      = 1'b0;
    out_item_nxt.end_of_transfer = last_byte;
    if (job.is_madctl) begin
      if (byte_idx_r == B_CASET) begin
        out_item_nxt.byte_value = CMD_MADCTL;
        out_item_nxt.is_command = 1'b1;
      end else begin
        out_item_nxt.byte_value = job.madctl;
      end
    end else begin
      case (byte_idx_r)
        B_CASET: begin
          out_item_nxt.byte_value = CMD_CASET;
          out_item_nxt.is_command = 1'b1;
        end
        B_X0_HI: out_item_nxt.byte_value = job.x0[15:8];
        B_X0_LO: out_item_nxt.byte_value = job.x0[7:0];
        B_X1_HI: out_item_nxt.byte_value = job.x1[15:8];
        B_X1_LO: out_item_nxt.byte_value = job.x1[7:0];
        B_RASET: begin
          out_item_nxt.byte_value = CMD_RASET;
          out_item_nxt.is_command = 1'b1;
        end
        B_Y0_HI: out_item_nxt.byte_value = job.y0[15:8];
        B_Y0_LO: out_item_nxt.byte_value = job.y0[7:0];
        B_Y1_HI: out_item_nxt.byte_value = job.y1[15:8];
        B_Y1_LO: out_item_nxt.byte_value = job.y1[7:0];
        default: begin
          out_item_nxt.byte_value = CMD_RAMWR;
          out_item_nxt.is_command = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    out_strobe_nxt = active;
    if (!active || last_byte) byte_idx_nxt = B_CASET;
    else byte_idx_nxt = byte_idx_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_idx_r   <= B_CASET;
      out_strobe_r <= 1'b0;
    end else begin
      byte_idx_r   <= byte_idx_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_idx_r <= B_RAMWR)
    else $error("byte index past end of sequence");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(active))
    else $error("byte sent without a queued request");

  a_eot_then_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_item_r.end_of_transfer) |-> (byte_idx_r == B_CASET))
    else $error("sequence did not restart after end of transfer");

endmodule

FILE: tb/sv/tb_top.sv
module tb_top;
  import lcdw_pkg::*;

  // cycles with no transfer on any port before the run is abandoned
  localparam int WATCHDOG_LIMIT  = 2000;
  // quiet cycles after the last expected byte before a register write
  localparam int SETTLE_CYCLES   = 4;
  // cycles watched for stray bytes once everything has drained
  localparam int TAIL_CYCLES     = 32;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 60;

  // register indexes past the end of the map, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_PAST_LAST = CFG_ROTATION + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_INDEX = '1;

  // one line of stimulus: either a register write or a request, with an
  // optional hand-typed expectation for the request
  typedef struct packed {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [COORD_W-1:0]   reg_val;
    in_item_t             req;
    logic                 typed;
    logic [15:0]          x0;
    logic [15:0]          x1;
    logic [15:0]          y0;
    logic [15:0]          y1;
    logic [7:0]           madctl;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             in_item = '0;
  logic                 out_strobe;
  out_item_t            out_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data = '0;

  // travels alongside in_item so the checker sees the row of the accepted request
  dir_row_t want_row = '0;

  // shadow of the register file, at reset values
  logic [8:0] sh_x_off  = 9'd0;
  logic [8:0] sh_y_off  = 9'd0;
  logic [8:0] sh_width  = 9'd240;
  logic [8:0] sh_height = 9'd320;
  logic [1:0] sh_rot    = ROT_0;

  // madctl byte per orientation
  logic [7:0] madctl_for_rot [4] = '{8'h00, 8'hA0, 8'hC0, 8'h60};

  out_item_t pending_bytes[$];
  int        fault_count  = 0;
  int        quiet_cycles = 0;
  dir_row_t  directed[$];

  lcd_window_command_generator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // byte prediction
  // ---------------------------------------------------------------------------

  function automatic void push_byte(logic [7:0] value, logic cmd, logic last);
    out_item_t b;
    b.byte_value      = value;
    b.is_command      = cmd;
    b.end_of_transfer = last;
    pending_bytes.push_back(b);
  endfunction

  // column set, row set, memory write: eleven bytes in one transfer
  function automatic void queue_window_bytes(logic [15:0] x0, logic [15:0] x1,
                                             logic [15:0] y0, logic [15:0] y1);
    push_byte(CMD_CASET, 1'b1, 1'b0);
    push_byte(x0[15:8], 1'b0, 1'b0);
    push_byte(x0[7:0],  1'b0, 1'b0);
    push_byte(x1[15:8], 1'b0, 1'b0);
    push_byte(x1[7:0],  1'b0, 1'b0);
    push_byte(CMD_RASET, 1'b1, 1'b0);
    push_byte(y0[15:8], 1'b0, 1'b0);
    push_byte(y0[7:0],  1'b0, 1'b0);
    push_byte(y1[15:8], 1'b0, 1'b0);
    push_byte(y1[7:0],  1'b0, 1'b0);
    push_byte(CMD_RAMWR, 1'b1, 1'b1);
  endfunction

  function automatic void queue_madctl_bytes(logic [7:0] value);
    push_byte(CMD_MADCTL, 1'b1, 1'b0);
    push_byte(value, 1'b0, 1'b1);
  endfunction

  // map the corners through the shadow registers, all sums wrap at 16 bits
  function automatic void predict_request(in_item_t r);
    logic [15:0] row_base;
    logic [15:0] col_base;
    logic [15:0] xb;
    logic [15:0] yb;
    row_base = CTRL_ROWS - {7'd0, sh_y_off} - {7'd0, sh_height};
    col_base = CTRL_COLUMNS - {7'd0, sh_x_off} - {7'd0, sh_width};
    if (r.req_type == REQ_MADCTL) begin
      // corner fields play no part here
      queue_madctl_bytes(madctl_for_rot[sh_rot]);
      return;
    end
    case (sh_rot)
      ROT_0: begin
        xb = {7'd0, sh_x_off};
        yb = {7'd0, sh_y_off};
      end
      ROT_90: begin
        xb = row_base;
        yb = {7'd0, sh_x_off};
      end
      ROT_180: begin
        xb = col_base;
        yb = row_base;
      end
      default: begin
        xb = {7'd0, sh_y_off};
        yb = col_base;
      end
    endcase
    queue_window_bytes(xb + {7'd0, r.first_x}, xb + {7'd0, r.last_x},
                       yb + {7'd0, r.first_y}, yb + {7'd0, r.last_y});
  endfunction

  // ---------------------------------------------------------------------------
  // checker: register shadow, expectations and byte comparison, all sampled
  // at the edge so nothing hangs on event order within a step
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(string field, logic [7:0] want, logic [7:0] got);
    fault_count++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
  endtask

  always @(posedge clk) begin : check_bytes
    out_item_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_X_OFFSET:     sh_x_off  <= cfg_data;
          CFG_Y_OFFSET:     sh_y_off  <= cfg_data;
          CFG_PANEL_WIDTH:  sh_width  <= cfg_data;
          CFG_PANEL_HEIGHT: sh_height <= cfg_data;
          CFG_ROTATION:     sh_rot    <= cfg_data[1:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (want_row.typed) begin
          if (in_item.req_type == REQ_MADCTL)
            queue_madctl_bytes(want_row.madctl);
          else
            queue_window_bytes(want_row.x0, want_row.x1, want_row.y0, want_row.y1);
        end else begin
          predict_request(in_item);
        end
      end
      if (out_strobe) begin
        if (pending_bytes.size() == 0) begin
          fault_count++;
          $display("%0t: byte with nothing expected, expected none, actual %h/%b/%b",
                   $time, out_item.byte_value, out_item.is_command,
                   out_item.end_of_transfer);
        end else begin
          want = pending_bytes.pop_front();
          if (out_item.byte_value !== want.byte_value)
            flag_mismatch("byte_value", want.byte_value, out_item.byte_value);
          if (out_item.is_command !== want.is_command)
            flag_mismatch("is_command", {7'd0, want.is_command}, {7'd0, out_item.is_command});
          if (out_item.end_of_transfer !== want.end_of_transfer)
            flag_mismatch("end_of_transfer", {7'd0, want.end_of_transfer},
                          {7'd0, out_item.end_of_transfer});
        end
      end
    end
  end

  // watchdog: any transfer on any port counts as progress
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus rows
  // ---------------------------------------------------------------------------

  function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    dir_row_t row;
    row         = '0;
    row.is_reg  = 1'b1;
    row.reg_idx = idx;
    row.reg_val = val;
    return row;
  endfunction

  function automatic dir_row_t req_row(logic rt, int fx, int fy, int lx, int ly);
    dir_row_t row;
    row              = '0;
    row.req.req_type = rt;
    row.req.first_x  = COORD_W'(fx);
    row.req.first_y  = COORD_W'(fy);
    row.req.last_x   = COORD_W'(lx);
    row.req.last_y   = COORD_W'(ly);
    return row;
  endfunction

  // window with its controller coordinates typed in
  function automatic dir_row_t window_row(int fx, int fy, int lx, int ly,
                                          int x0, int x1, int y0, int y1);
    dir_row_t row;
    row       = req_row(REQ_WINDOW, fx, fy, lx, ly);
    row.typed = 1'b1;
    row.x0    = 16'(x0);
    row.x1    = 16'(x1);
    row.y0    = 16'(y0);
    row.y1    = 16'(y1);
    return row;
  endfunction

  // orientation request with its madctl byte typed in, corners are junk
  function automatic dir_row_t madctl_row(int corner, logic [7:0] value);
    dir_row_t row;
    row        = req_row(REQ_MADCTL, corner, corner, corner, corner);
    row.typed  = 1'b1;
    row.madctl = value;
    return row;
  endfunction

  // corners mostly on the panel, sometimes anywhere in 9 bits, sometimes at the edges
  function automatic int random_corner(int mode);
    int pick;
    case (mode)
      0: return $urandom_range(0, 511);
      1: begin
        pick = $urandom_range(0, 2);
        return (pick == 0) ? 0 : (pick == 1) ? 319 : 511;
      end
      default: return $urandom_range(0, 319);
    endcase
  endfunction

  function automatic dir_row_t random_row();
    logic rt;
    int   mode;
    rt   = ($urandom_range(0, 3) == 0) ? REQ_MADCTL : REQ_WINDOW;
    mode = $urandom_range(0, 6);
    return req_row(rt, random_corner(mode), random_corner(mode),
                   random_corner(mode), random_corner(mode));
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // holds start high until the request is taken; start is left high so a
  // back-to-back request needs no second assignment in the same step
  task automatic send_request(dir_row_t row);
    start    <= 1'b1;
    in_item  <= row.req;
    want_row <= row;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_sender(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // sender pauses until every expected byte is out, then lets the pipe settle
  task automatic await_drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_bytes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_valid stays high between writes of one batch, the caller lowers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    logic reg_batch_open;
    int   idle_pct;
    int   pick;
    logic [COORD_W-1:0] xo, yo, wd, ht, rot;

    directed = '{
      // reset values put every base at zero, so the corners pass straight through
      window_row(0, 0, 0, 0,           0, 0, 0, 0),
      window_row(0, 0, 239, 319,       0, 239, 0, 319),
      window_row(511, 511, 511, 511,   511, 511, 511, 511),
      // reversed corners are sent as they are
      window_row(319, 319, 0, 0,       319, 0, 319, 0),
      madctl_row(0, 8'h00),
      reg_row(CFG_ROTATION, COORD_W'(ROT_90)),
      madctl_row(511, 8'hA0),
      window_row(10, 20, 30, 40,       10, 30, 20, 40),
      reg_row(CFG_ROTATION, COORD_W'(ROT_180)),
      madctl_row(0, 8'hC0),
      window_row(5, 6, 7, 8,           5, 7, 6, 8),
      reg_row(CFG_ROTATION, COORD_W'(ROT_270)),
      madctl_row(511, 8'h60),
      window_row(1, 2, 3, 4,           1, 3, 2, 4),
      // offsets and panel size at their 9-bit top, bases go negative and wrap
      reg_row(CFG_X_OFFSET, 9'h1FF),
      reg_row(CFG_Y_OFFSET, 9'h1FF),
      reg_row(CFG_PANEL_WIDTH, 9'h1FF),
      reg_row(CFG_PANEL_HEIGHT, 9'h1FF),
      req_row(REQ_WINDOW, 0, 0, 511, 511),
      // upper data bits of the rotation write are dropped
      reg_row(CFG_ROTATION, 9'h1FE),
      req_row(REQ_WINDOW, 0, 0, 511, 511),
      req_row(REQ_MADCTL, 511, 0, 511, 0),
      reg_row(CFG_ROTATION, 9'h1FD),
      req_row(REQ_WINDOW, 319, 0, 0, 319),
      reg_row(CFG_ROTATION, COORD_W'(ROT_0)),
      req_row(REQ_WINDOW, 511, 511, 0, 0),
      // zero-sized panel, outside the legal range but used as given
      reg_row(CFG_X_OFFSET, 9'h000),
      reg_row(CFG_Y_OFFSET, 9'h000),
      reg_row(CFG_PANEL_WIDTH, 9'h000),
      reg_row(CFG_PANEL_HEIGHT, 9'h000),
      reg_row(CFG_ROTATION, COORD_W'(ROT_90)),
      req_row(REQ_WINDOW, 0, 0, 319, 319),
      reg_row(CFG_ROTATION, COORD_W'(ROT_180)),
      req_row(REQ_WINDOW, 0, 0, 319, 319),
      // writes past the end of the map must leave everything alone
      reg_row(CFG_PAST_LAST, 9'h1FF),
      reg_row(CFG_TOP_INDEX, 9'h155),
      req_row(REQ_WINDOW, 1, 1, 2, 2),
      req_row(REQ_MADCTL, 0, 0, 0, 0)
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    reg_batch_open = 1'b0;
    foreach (directed[i]) begin
      if (directed[i].is_reg) begin
        if (!reg_batch_open)
          await_drain();
        write_reg(directed[i].reg_idx, directed[i].reg_val);
        reg_batch_open = 1'b1;
      end else begin
        if (reg_batch_open) begin
          cfg_valid <= 1'b0;
          reg_batch_open = 1'b0;
        end
        send_request(directed[i]);
      end
    end

    // random phases, each under its own register setting
    for (int ph = 0; ph < N_PHASES; ph++) begin
      await_drain();
      case (ph % 4)
        0: begin
          // legal panel geometry
          xo = COORD_W'($urandom_range(0, 319));
          yo = COORD_W'($urandom_range(0, 319));
          wd = COORD_W'($urandom_range(1, 320));
          ht = COORD_W'($urandom_range(1, 320));
        end
        2: begin
          // alternate between all-zero and all-ones registers
          xo = (ph % 8 == 2) ? '1 : '0;
          yo = xo;
          wd = xo;
          ht = xo;
        end
        default: begin
          xo = COORD_W'($urandom_range(0, 511));
          yo = COORD_W'($urandom_range(0, 511));
          wd = COORD_W'($urandom_range(0, 511));
          ht = COORD_W'($urandom_range(0, 511));
        end
      endcase
      rot = COORD_W'($urandom_range(0, 511));
      write_reg(CFG_X_OFFSET, xo);
      write_reg(CFG_Y_OFFSET, yo);
      write_reg(CFG_PANEL_WIDTH, wd);
      write_reg(CFG_PANEL_HEIGHT, ht);
      write_reg(CFG_ROTATION, rot);
      write_reg(CFG_IDX_W'(CFG_ROTATION + $urandom_range(1, 3)),
                COORD_W'($urandom_range(0, 511)));
      cfg_valid <= 1'b0;

      // last phase runs flat out, others pick none, light or heavy gaps
      if (ph == N_PHASES - 1) begin
        idle_pct = 0;
      end else begin
        pick     = $urandom_range(0, 2);
        idle_pct = (pick == 0) ? 0 : (pick == 1) ? 25 : 60;
      end

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
          idle_sender($urandom_range(1, 16));
        else if (ph != N_PHASES - 1 && $urandom_range(0, 39) == 0)
          await_drain();
        send_request(random_row());
      end
    end

    await_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_bytes.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
